// ===== sv/heightmap_triangle_height_query_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heightmap triangle height query block
// Shared concurrent assertion forms, clocked on clk_i; only HTQ_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_TOP_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define HTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define HTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/htq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htq_pkg
// Widths, codes and shared types of the heightmap triangle height query block.
// ----------------------------------------------------------------------------
package htq_pkg;

  localparam int GRID_CELLS  = 64;
  localparam int SAMPLE_BITS = 8;

  // Fixed field widths.
  localparam int BS_W    = 7;
  localparam int SP_W    = 16;
  localparam int INV_W   = 24;
  localparam int SC_W    = 16;
  localparam int OFS_W   = 24;
  localparam int IDX_W   = 7;
  localparam int SMPIN_W = 8;
  localparam int Q_W     = 24;
  localparam int H_W     = 26;

  // Fixed-point layout.
  localparam int Q_FRAC    = 8;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int CELL_SH   = Q_FRAC + FRAC_BITS;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_BITS);

  localparam int W_W    = BS_W + SP_W;
  localparam int PS_W   = Q_W + 2;
  localparam int PROD_W = W_W + INV_W;
  localparam int D_W    = SAMPLE_BITS + 1;
  localparam int PP_W   = D_W + FRAC_W + 1;
  localparam int RS_W   = PP_W + 2;
  localparam int R_W    = SAMPLE_BITS + FRAC_BITS;
  localparam int M_W    = R_W + SC_W;
  localparam int HS_W   = H_W + 2;
  localparam int H_MAX  = (1 << (H_W - 1)) - 1;
  localparam int H_MIN  = -(1 << (H_W - 1));

  // Height store banks: one bank per row and column parity.
  localparam int BANKS      = 4;
  localparam int BANK_SIDE  = GRID_CELLS / 2 + 1;
  localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Queues.
  localparam int QUEUE_DEPTH = 8;
  localparam int OUT_DEPTH   = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + OUT_DEPTH) + 1;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_SPACING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SPACING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_OFFSET   = 3'd4;

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  typedef struct packed {
    logic [BS_W-1:0]         n;
    logic [W_W-1:0]          w;
    logic [INV_W-1:0]        inv;
    logic [SC_W-1:0]         scale;
    logic signed [OFS_W-1:0] offset;
  } cfg_t;

  // One classified word between the front and the back.
  typedef struct packed {
    logic              kind;
    logic              outside;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
    smp_t              sample;
  } entry_t;

endpackage

// ===== sv/htq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htq_in_if / htq_out_if
// Valid/ready channels for load and query words and for height results.
// ----------------------------------------------------------------------------
interface htq_in_if;
  import htq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [IDX_W-1:0]      grid_row;
  logic [IDX_W-1:0]      grid_col;
  logic [SMPIN_W-1:0]    sample_value;
  logic signed [Q_W-1:0] query_x;
  logic signed [Q_W-1:0] query_z;

  modport source (output valid, kind, grid_row, grid_col, sample_value, query_x, query_z,
                  input ready);
  modport sink   (input valid, kind, grid_row, grid_col, sample_value, query_x, query_z,
                  output ready);
endinterface

interface htq_out_if;
  import htq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [H_W-1:0] terrain_height;
  logic                  outside;

  modport source (output valid, terrain_height, outside, input ready);
  modport sink   (input valid, terrain_height, outside, output ready);
endinterface

// ===== sv/heightmap_triangle_height_query_top.sv =====
`timescale 1ns / 1ps
// A query passes the front, the queue, the bank read, interpolation and scaling registers and
// the result buffer; a load gives no word and is written to the store as it leaves the queue.
// Throughput: one word per cycle while both queues have room, set by the 4-bank height store
// that reads all corners at once. Reset clears the configuration to its defaults and empties
// both queues; the height store is not cleared and holds undefined samples until loaded.
// ----------------------------------------------------------------------------
// heightmap_triangle_height_query_top
// Height sample grid with triangle-interpolated height queries.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_query_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  htq_in_if.sink                         in_i,
  htq_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [htq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [htq_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import htq_pkg::*;

  cfg_t              cfg;
  logic [CNT_W-1:0]  q_cnt;
  logic              push, q_valid, pop;
  entry_t            push_entry, head_entry;

  htq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  htq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .q_cnt_i (q_cnt),
    .push_o  (push),
    .entry_o (push_entry)
  );

  htq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .cnt_o   (q_cnt)
  );

  htq_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_entry_i (head_entry),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

// ===== sv/htq_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htq_cfg
// Configuration registers, with the clamped cell count and patch width.
// ----------------------------------------------------------------------------
module htq_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [htq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [htq_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output htq_pkg::cfg_t                  cfg_o
);
  import htq_pkg::*;

  logic [BS_W-1:0]         bs_q;
  logic [SP_W-1:0]         sp_q;
  logic [INV_W-1:0]        inv_q;
  logic [SC_W-1:0]         sc_q;
  logic signed [OFS_W-1:0] ofs_q;
  logic [BS_W-1:0]         n_d, n_q;
  logic [W_W-1:0]          w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q  <= BS_W'(64);
      sp_q  <= SP_W'(256);
      inv_q <= INV_W'(65536);
      sc_q  <= SC_W'(256);
      ofs_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLOCK_SIZE:      bs_q  <= cfg_data_i[BS_W-1:0];
        CFG_VERTEX_SPACING:  sp_q  <= cfg_data_i[SP_W-1:0];
        CFG_INVERSE_SPACING: inv_q <= cfg_data_i[INV_W-1:0];
        CFG_HEIGHT_SCALE:    sc_q  <= cfg_data_i[SC_W-1:0];
        CFG_HEIGHT_OFFSET:   ofs_q <= $signed(cfg_data_i[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bs_q == '0) begin
      n_d = BS_W'(1);
    end else if (bs_q > BS_W'(GRID_CELLS)) begin
      n_d = BS_W'(GRID_CELLS);
    end else begin
      n_d = bs_q;
    end
  end

  // The clamped size and the width are registered again after the configuration registers,
  // settling before any word accepted after a write reaches the stage that uses them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= BS_W'(64);
      w_q <= W_W'(64 * 256);
    end else begin
      n_q <= n_d;
      w_q <= W_W'(n_d) * W_W'(sp_q);
    end
  end

  assign cfg_o.n      = n_q;
  assign cfg_o.w      = w_q;
  assign cfg_o.inv    = inv_q;
  assign cfg_o.scale  = sc_q;
  assign cfg_o.offset = ofs_q;

endmodule

// ===== sv/htq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htq_front
// Accepts words, centers query points, checks the extent and finds the cell.
// ----------------------------------------------------------------------------
module htq_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  htq_in_if.sink                     in_i,
  input  htq_pkg::cfg_t              cfg_i,
  input  logic [htq_pkg::CNT_W-1:0]  q_cnt_i,
  output logic                       push_o,
  output htq_pkg::entry_t            entry_o
);
  import htq_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W-1:0] frac;
  } cell_t;

  function automatic cell_t to_cell(input logic [PROD_W-1:0] p, input logic [BS_W-1:0] n);
    cell_t                       c;
    logic [PROD_W-CELL_SH-1:0]   whole;
    whole = p[PROD_W-1:CELL_SH];
    if (whole >= (PROD_W-CELL_SH)'(n)) begin
      c.idx  = IDX_W'(n - 1'b1);
      c.frac = FRAC_ONE;
    end else begin
      c.idx  = whole[IDX_W-1:0];
      c.frac = {1'b0, p[CELL_SH-1:Q_FRAC]};
    end
    return c;
  endfunction

  logic                  accept;
  logic [CNT_W-1:0]      fill;

  logic                  v0_q, kind0_q;
  logic [IDX_W-1:0]      row0_q, col0_q;
  smp_t                  smp0_q;
  logic signed [Q_W-1:0] qx0_q, qz0_q;

  logic signed [PS_W-1:0] w_s, half_s, px_s, pz_s;
  logic                   q_out, load_bad;

  logic                  v1_q, kind1_q, out1_q;
  logic [IDX_W-1:0]      row1_q, col1_q;
  smp_t                  smp1_q;
  logic [W_W-1:0]        px1_q, pz1_q;

  logic                  v2_q, kind2_q, out2_q;
  logic [IDX_W-1:0]      row2_q, col2_q;
  smp_t                  smp2_q;
  logic [PROD_W-1:0]     prx2_q, prz2_q;
  cell_t                 cx, cz;

  // Everything in flight ahead of the queue holds a queue slot.
  assign fill       = q_cnt_i + CNT_W'(v0_q) + CNT_W'(v1_q) + CNT_W'(v2_q);
  assign in_i.ready = fill < CNT_W'(QUEUE_DEPTH);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind0_q <= in_i.kind;
    row0_q  <= in_i.grid_row;
    col0_q  <= in_i.grid_col;
    smp0_q  <= smp_t'(in_i.sample_value);
    qx0_q   <= in_i.query_x;
    qz0_q   <= in_i.query_z;
  end

  // Center the point on the patch, z flipped.
  always_comb begin
    w_s      = $signed(PS_W'(cfg_i.w));
    half_s   = $signed(PS_W'(cfg_i.w >> 1));
    px_s     = PS_W'(qx0_q) + half_s;
    pz_s     = half_s - PS_W'(qz0_q);
    q_out    = (px_s < 0) || (px_s > w_s) || (pz_s < 0) || (pz_s > w_s);
    load_bad = (row0_q > IDX_W'(GRID_CELLS)) || (col0_q > IDX_W'(GRID_CELLS));
  end

  // For a load the outside bit marks a sample that lands beyond the grid.
  always_ff @(posedge clk_i) begin
    kind1_q <= kind0_q;
    out1_q  <= (kind0_q == KIND_QUERY) ? q_out : load_bad;
    row1_q  <= row0_q;
    col1_q  <= col0_q;
    smp1_q  <= smp0_q;
    px1_q   <= px_s[W_W-1:0];
    pz1_q   <= pz_s[W_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    kind2_q <= kind1_q;
    out2_q  <= out1_q;
    row2_q  <= row1_q;
    col2_q  <= col1_q;
    smp2_q  <= smp1_q;
    prx2_q  <= PROD_W'(px1_q) * PROD_W'(cfg_i.inv);
    prz2_q  <= PROD_W'(pz1_q) * PROD_W'(cfg_i.inv);
  end

  always_comb begin
    cx = to_cell(prx2_q, cfg_i.n);
    cz = to_cell(prz2_q, cfg_i.n);
    entry_o.kind    = kind2_q;
    entry_o.outside = out2_q;
    entry_o.sample  = smp2_q;
    if (kind2_q == KIND_QUERY) begin
      entry_o.row = cz.idx;
      entry_o.col = cx.idx;
      entry_o.fx  = cx.frac;
      entry_o.fz  = cz.frac;
    end else begin
      entry_o.row = row2_q;
      entry_o.col = col2_q;
      entry_o.fx  = '0;
      entry_o.fz  = '0;
    end
  end

  assign push_o = v2_q;

endmodule

// ===== sv/htq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htq_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module htq_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  htq_pkg::entry_t            entry_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output htq_pkg::entry_t            entry_o,
  output logic [htq_pkg::CNT_W-1:0]  cnt_o
);
  import htq_pkg::*;
  `include "heightmap_triangle_height_query_top_defines.svh"

  localparam int QA_W = $clog2(QUEUE_DEPTH);

  entry_t            slot_q [QUEUE_DEPTH];
  logic [QA_W-1:0]   wp_q, rp_q;
  logic [CNT_W-1:0]  cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rp_q];
  assign cnt_o   = cnt_q;

  `HTQ_ASSERT(a_queue_no_overflow, push_i |-> (cnt_q < CNT_W'(QUEUE_DEPTH)), "queue overflow")
  `HTQ_ASSERT(a_queue_no_underflow, pop_i |-> valid_o, "pop from empty queue")
  `HTQ_ASSERT(a_queue_cnt_range, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== sv/htq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htq_back
// Banked height store, triangle interpolation, scaling and result buffer.
// ----------------------------------------------------------------------------
module htq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  htq_pkg::cfg_t    cfg_i,
  input  logic             q_valid_i,
  input  htq_pkg::entry_t  q_entry_i,
  output logic             pop_o,
  htq_out_if.source        out_o
);
  import htq_pkg::*;
  `include "heightmap_triangle_height_query_top_defines.svh"

  localparam int OA_W = $clog2(OUT_DEPTH);

  typedef struct packed {
    logic signed [H_W-1:0] height;
    logic                  outside;
  } res_t;

  function automatic logic [BANK_AW-1:0] bank_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
    return BANK_AW'(BANK_AW'(r >> 1) * BANK_AW'(BANK_SIDE) + BANK_AW'(c >> 1));
  endfunction

  logic              credit, we, rd_en;
  logic [CNT_W-1:0]  inflight;
  logic [1:0]        wbank;
  logic [BANK_AW-1:0] waddr;
  logic [BANK_AW-1:0] raddr [BANKS];
  logic [IDX_W-1:0]  r_even, r_odd, c_even, c_odd;
  smp_t              rd_data [BANKS];

  logic              b1v_q, b1out_q, b1rp_q, b1cp_q;
  logic [FRAC_W-1:0] fx1_q, fz1_q;
  smp_t              tl, tr, bl, br, base;
  logic [FRAC_W:0]   fsum;
  logic signed [D_W-1:0] da, db;
  logic [FRAC_W-1:0] fa, fb;

  logic              b2v_q, b2out_q;
  smp_t              base2_q;
  logic signed [PP_W-1:0] p1_q, p2_q;
  logic signed [RS_W-1:0] r_s;

  logic              b3v_q, b3out_q;
  logic [R_W-1:0]    r3_q;

  logic              b4v_q, b4out_q;
  logic [M_W-1:0]    m4_q;
  logic [M_W:0]      rnd;
  logic signed [HS_W-1:0] h_s;
  res_t              res;

  res_t              obuf_q [OUT_DEPTH];
  logic [OA_W-1:0]   owp_q, orp_q;
  logic [CNT_W-1:0]  ocnt_q;
  logic              opop;

  // Results still in the pipe hold a slot of the output buffer.
  assign inflight = ocnt_q + CNT_W'(b1v_q) + CNT_W'(b2v_q) + CNT_W'(b3v_q) + CNT_W'(b4v_q);
  assign credit   = inflight < CNT_W'(OUT_DEPTH);
  assign pop_o    = q_valid_i && credit;

  assign we    = pop_o && (q_entry_i.kind == KIND_LOAD) && !q_entry_i.outside;
  assign rd_en = pop_o && (q_entry_i.kind == KIND_QUERY);
  assign wbank = {q_entry_i.row[0], q_entry_i.col[0]};
  assign waddr = bank_addr(q_entry_i.row, q_entry_i.col);

  // The four corners of a cell always fall in four different banks.
  always_comb begin
    r_even   = q_entry_i.row[0] ? IDX_W'(q_entry_i.row + 1'b1) : q_entry_i.row;
    r_odd    = q_entry_i.row[0] ? q_entry_i.row : IDX_W'(q_entry_i.row + 1'b1);
    c_even   = q_entry_i.col[0] ? IDX_W'(q_entry_i.col + 1'b1) : q_entry_i.col;
    c_odd    = q_entry_i.col[0] ? q_entry_i.col : IDX_W'(q_entry_i.col + 1'b1);
    raddr[0] = bank_addr(r_even, c_even);
    raddr[1] = bank_addr(r_even, c_odd);
    raddr[2] = bank_addr(r_odd, c_even);
    raddr[3] = bank_addr(r_odd, c_odd);
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    smp_t mem [BANK_DEPTH];
    smp_t rd_q;
    always_ff @(posedge clk_i) begin
      if (we && (wbank == 2'(b))) begin
        mem[waddr] <= q_entry_i.sample;
      end
      if (rd_en) begin
        rd_q <= mem[raddr[b]];
      end
    end
    assign rd_data[b] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1v_q <= 1'b0;
      b2v_q <= 1'b0;
      b3v_q <= 1'b0;
      b4v_q <= 1'b0;
    end else begin
      b1v_q <= rd_en;
      b2v_q <= b1v_q;
      b3v_q <= b2v_q;
      b4v_q <= b3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1out_q <= q_entry_i.outside;
    b1rp_q  <= q_entry_i.row[0];
    b1cp_q  <= q_entry_i.col[0];
    fx1_q   <= q_entry_i.fx;
    fz1_q   <= q_entry_i.fz;
  end

  // Pick the triangle on the top-right to bottom-left diagonal.
  always_comb begin
    tl   = rd_data[{b1rp_q, b1cp_q}];
    tr   = rd_data[{b1rp_q, ~b1cp_q}];
    bl   = rd_data[{~b1rp_q, b1cp_q}];
    br   = rd_data[{~b1rp_q, ~b1cp_q}];
    fsum = {1'b0, fx1_q} + {1'b0, fz1_q};
    if (fsum < (FRAC_W+1)'(FRAC_ONE)) begin
      base = tl;
      da   = $signed({1'b0, tr}) - $signed({1'b0, tl});
      db   = $signed({1'b0, bl}) - $signed({1'b0, tl});
      fa   = fx1_q;
      fb   = fz1_q;
    end else begin
      base = br;
      da   = $signed({1'b0, bl}) - $signed({1'b0, br});
      db   = $signed({1'b0, tr}) - $signed({1'b0, br});
      fa   = FRAC_ONE - fx1_q;
      fb   = FRAC_ONE - fz1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b2out_q <= b1out_q;
    base2_q <= base;
    p1_q    <= da * $signed({1'b0, fa});
    p2_q    <= db * $signed({1'b0, fb});
  end

  assign r_s = RS_W'($signed({1'b0, base2_q, {FRAC_BITS{1'b0}}})) + RS_W'(p1_q) + RS_W'(p2_q);

  always_ff @(posedge clk_i) begin
    b3out_q <= b2out_q;
    r3_q    <= (r_s < 0) ? '0 : r_s[R_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    b4out_q <= b3out_q;
    m4_q    <= M_W'(r3_q) * M_W'(cfg_i.scale);
  end

  // Round half up, add the offset, saturate to the result width; an outside point gives height zero.
  always_comb begin
    rnd = (M_W+1)'(m4_q) + (M_W+1)'(1 << (FRAC_BITS - 1));
    h_s = HS_W'(cfg_i.offset) + $signed(HS_W'(rnd[M_W:FRAC_BITS]));
    res.outside = b4out_q;
    if (b4out_q) begin
      res.height = '0;
    end else if (h_s > H_MAX) begin
      res.height = H_W'(H_MAX);
    end else if (h_s < H_MIN) begin
      res.height = H_W'(H_MIN);
    end else begin
      res.height = h_s[H_W-1:0];
    end
  end

  assign opop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (b4v_q) begin
      obuf_q[owp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (b4v_q) owp_q <= owp_q + 1'b1;
      if (opop)  orp_q <= orp_q + 1'b1;
      ocnt_q <= ocnt_q + CNT_W'(b4v_q) - CNT_W'(opop);
    end
  end

  assign out_o.valid          = (ocnt_q != '0);
  assign out_o.terrain_height = obuf_q[orp_q].height;
  assign out_o.outside        = obuf_q[orp_q].outside;

  `HTQ_ASSERT(a_obuf_no_overflow, b4v_q |-> (ocnt_q < CNT_W'(OUT_DEPTH)), "result buffer overflow")
  `HTQ_ASSERT(a_load_no_result, (pop_o && q_entry_i.kind == KIND_LOAD) |=> !b1v_q, "load made a result")
  `HTQ_ASSERT(a_no_read_and_write, !(we && rd_en), "store read and written together")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap triangle height query testbench
// Loads the used part of the height grid, then sends directed and random load
// and query words under several register settings and handshake idling
// patterns. A scoreboard predicts each query's height and outside flag and
// checks every result word in order.
// ----------------------------------------------------------------------------
module tb;
  import htq_pkg::*;

  localparam int STRIDE = GRID_CELLS + 1;
  localparam longint ONE_Q16 = 65536;
  // Rows and columns 0 to FILL_CELLS are loaded up front; every query keeps
  // its corners inside that square.
  localparam int FILL_CELLS = 33;

  typedef struct {
    logic                  kind;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic [SMPIN_W-1:0]    sample;
    logic signed [Q_W-1:0] qx;
    logic signed [Q_W-1:0] qz;
  } word_t;

  typedef struct {
    logic signed [H_W-1:0] height;
    logic                  outside;
  } height_t;

  class height_scoreboard;
    logic [SAMPLE_BITS-1:0] grid[STRIDE*STRIDE];
    int unsigned bsz = 64, spacing = 256, inv_sp = 65536, scale = 256;
    longint offset = 0;
    height_t pending[$];
    int errors = 0, queries = 0, loads = 0, outsides = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_BLOCK_SIZE:      bsz = 32'(data[BS_W-1:0]);
        CFG_VERTEX_SPACING:  spacing = 32'(data[SP_W-1:0]);
        CFG_INVERSE_SPACING: inv_sp = 32'(data[INV_W-1:0]);
        CFG_HEIGHT_SCALE:    scale = 32'(data[SC_W-1:0]);
        CFG_HEIGHT_OFFSET:   offset = longint'($signed(data[OFS_W-1:0]));
        default: ;
      endcase
    endfunction

    function void locate(longint p, longint n, output longint idx, output longint frac);
      longint u;
      u = (p * longint'(inv_sp)) >>> 8;
      if ((u >>> 16) >= n) begin
        idx  = n - 1;
        frac = ONE_Q16;
      end else begin
        idx  = u >>> 16;
        frac = u & 'hFFFF;
      end
    endfunction

    function void note_input(word_t it);
      longint n, w, half, px, pz, col, row, fx, fz, tl, tr, bl, br, r, h;
      height_t e;
      if (it.kind == KIND_LOAD) begin
        if (it.row <= GRID_CELLS && it.col <= GRID_CELLS)
          grid[it.row * STRIDE + it.col] = it.sample[SAMPLE_BITS-1:0];
        loads++;
        return;
      end
      queries++;
      n = longint'((bsz < 1) ? 1 : (bsz > GRID_CELLS) ? GRID_CELLS : bsz);
      w = n * longint'(spacing);
      half = w / 2;
      px = longint'(it.qx) + half;
      pz = -longint'(it.qz) + half;
      if (px < 0 || px > w || pz < 0 || pz > w) begin
        e.height = '0;
        e.outside = 1'b1;
        outsides++;
      end else begin
        locate(px, n, col, fx);
        locate(pz, n, row, fz);
        tl = longint'(grid[row * STRIDE + col]);
        tr = longint'(grid[row * STRIDE + col + 1]);
        bl = longint'(grid[(row + 1) * STRIDE + col]);
        br = longint'(grid[(row + 1) * STRIDE + col + 1]);
        // The cell is split on the diagonal from top-right to bottom-left.
        if (fx + fz < ONE_Q16)
          r = tl * ONE_Q16 + (tr - tl) * fx + (bl - tl) * fz;
        else
          r = br * ONE_Q16 + (bl - br) * (ONE_Q16 - fx) + (tr - br) * (ONE_Q16 - fz);
        if (r < 0) r = 0;
        h = offset + ((r * longint'(scale) + 32768) >>> 16);
        if (h > H_MAX) h = H_MAX;
        if (h < H_MIN) h = H_MIN;
        e.height = h[H_W-1:0];
        e.outside = 1'b0;
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [H_W-1:0] height, logic outside);
      height_t e;
      if (pending.size() == 0) begin
        $error("result word with no query waiting: height %0d outside %0b", height, outside);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (height !== e.height) begin
        $error("terrain_height: expected %0d, got %0d", e.height, height);
        errors++;
      end
      if (outside !== e.outside) begin
        $error("outside: expected %0b, got %0b", e.outside, outside);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  htq_in_if in_if ();
  htq_out_if out_if ();

  heightmap_triangle_height_query_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if.sink),
    .out_o     (out_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  height_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = KIND_LOAD;
    in_if.grid_row = '0;
    in_if.grid_col = '0;
    in_if.sample_value = '0;
    in_if.query_x = '0;
    in_if.query_z = '0;
    out_if.ready = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off.
  always @(posedge clk_i) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.terrain_height, out_if.outside);
  end

  task automatic send_word(word_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= it.kind;
    in_if.grid_row <= it.row;
    in_if.grid_col <= it.col;
    in_if.sample_value <= it.sample;
    in_if.query_x <= it.qx;
    in_if.query_z <= it.qz;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_input(it);
  endtask

  task automatic send_load(int row, int col, int sample);
    word_t it;
    it.kind = KIND_LOAD;
    it.row = IDX_W'(row);
    it.col = IDX_W'(col);
    it.sample = SMPIN_W'(sample);
    it.qx = Q_W'($urandom);
    it.qz = Q_W'($urandom);
    send_word(it);
  endtask

  task automatic send_query(longint x, longint z);
    word_t it;
    it.kind = KIND_QUERY;
    it.row = IDX_W'($urandom);
    it.col = IDX_W'($urandom);
    it.sample = SMPIN_W'($urandom);
    it.qx = x[Q_W-1:0];
    it.qz = z[Q_W-1:0];
    send_word(it);
  endtask

  // Registers change only with the pipeline drained; a load has no result
  // word, so a further idle wait covers one still on its way to the store.
  task automatic write_regs(int bs, int sp, int inv, int sc, int ofs);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      logic [CFG_IDX_W-1:0] idx;
      logic [CFG_DAT_W-1:0] val;
      idx = CFG_IDX_W'(i);
      case (idx)
        CFG_BLOCK_SIZE:      val = CFG_DAT_W'(bs);
        CFG_VERTEX_SPACING:  val = CFG_DAT_W'(sp);
        CFG_INVERSE_SPACING: val = CFG_DAT_W'(inv);
        CFG_HEIGHT_SCALE:    val = CFG_DAT_W'(sc);
        default:             val = CFG_DAT_W'(ofs);
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= val;
      @(posedge clk_i);
      sb.set_reg(idx, val);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_words(int count);
    longint n, w, half;
    n = longint'((sb.bsz < 1) ? 1 : (sb.bsz > GRID_CELLS) ? GRID_CELLS : sb.bsz);
    w = n * longint'(sb.spacing);
    half = w / 2;
    for (int i = 0; i < count; i++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 15)
        send_load($urandom_range(GRID_CELLS), $urandom_range(GRID_CELLS), $urandom);
      else if (pick < 18)
        send_load($urandom_range(127), $urandom_range(127), $urandom);
      else if (pick < 30)
        send_query(longint'($signed(Q_W'($urandom))), longint'($signed(Q_W'($urandom))));
      else
        send_query(longint'($urandom_range(32'(w + 2))) - half - 1,
                   half + 1 - longint'($urandom_range(32'(w + 2))));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the square that queries may touch so none reads an unwritten sample.
    for (int r = 0; r <= FILL_CELLS; r++)
      for (int c = 0; c <= FILL_CELLS; c++)
        send_load(r, c, $urandom);

    // Directed part, reset registers: extent 16384, half 8192.
    send_load(0, 0, 0);
    send_load(0, 1, 255);
    send_load(1, 0, 255);
    send_load(1, 1, 0);
    send_load(65, 3, 77);
    send_load(127, 127, 77);
    send_query(-8192, 8192);
    send_query(-8192 + 100, 8192 - 50);
    send_query(-8192 + 200, 8192 - 200);
    send_query(0, 0);
    send_query(8193, 0);
    send_query(-8193, 0);
    send_query(0, 8193);
    send_query(0, -8193);
    send_query(-8388608, -8388608);
    send_query(8388607, 8388607);
    send_query(-1, 1);
    send_query(-4095, 4095);

    write_regs(1, 65535, 1, 65535, 8388607);
    send_query(0, 0);
    send_query(32767, -32767);
    random_words(60);

    write_regs(0, 1, 16777215, 0, -8388608);
    send_query(0, 0);
    random_words(60);

    // Oversized block size: extent 64000, half 32000; points stay in the
    // top-left quarter of the patch.
    write_regs(127, 1000, 16777, 65535, 0);
    for (int i = 0; i < 20; i++)
      send_query(longint'($urandom_range(32000)) - 32000,
                 32000 - longint'($urandom_range(32000)));
    send_query(-32000, 32000);
    send_query(32001, 0);
    send_query(0, -32001);
    send_query(-32001, 0);

    for (int ph = 0; ph < 8; ph++) begin
      int sp;
      sp = ($urandom_range(3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 2000);
      write_regs($urandom_range(1, FILL_CELLS), sp,
                 (16777216 / sp) + $urandom_range(2) - 1 + ((sp == 1) ? -1 : 0),
                 $urandom_range(65535), $urandom);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      if (ph == 4) holdoff_cycles <= 300;
      random_words(55);
    end

    in_if.valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d loads and %0d queries (%0d outside the patch)",
             sb.loads, sb.queries, sb.outsides);
    $display("over extreme and random register settings and handshake stall patterns.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("heightmap_triangle_height_query_top verification clean");
    end else begin
      $display("heightmap_triangle_height_query_top verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("heightmap_triangle_height_query_top verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/htq_pkg.sv
sv/htq_if.sv
sv/htq_cfg.sv
sv/htq_front.sv
sv/htq_queue.sv
sv/htq_back.sv
sv/heightmap_triangle_height_query_top.sv
tb/tb.sv
